>>> hw/rtl/dspd_pkg.sv
package dspd_pkg;

    // Frame layout defaults
    localparam int HDR_WORDS_DEF = 16;
    localparam int CNT_BITS_DEF  = 16;

    // Jobs held between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    // Configuration port: byte address bits, one 32-bit register
    localparam int          ADDR_BITS    = 3;
    localparam logic        REG_ROW_WIDTH = 1'b0;
    localparam logic [7:0]  ROW_WIDTH_RST = 8'd160;

    // Row kinds that write a plane
    localparam logic [6:0] ROWK_TEMPORAL = 7'h10;
    localparam logic [6:0] ROWK_SPAT_L   = 7'h14;
    localparam logic [6:0] ROWK_SPAT_R   = 7'h16;

    // Plane codes, PLANE_NONE for a row kind that writes nothing
    localparam logic [1:0] PLANE_TEMPORAL = 2'd0;
    localparam logic [1:0] PLANE_SPAT_L   = 2'd1;
    localparam logic [1:0] PLANE_SPAT_R   = 2'd2;
    localparam logic [1:0] PLANE_NONE     = 2'd3;

    // 2-bit mode group that carries only four pixels
    localparam logic [4:0] GROUP_SHORT = 5'hd;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ROW_LOST = 2'd1,
        ST_BAD_PREC = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PREC_8 = 2'd0,
        PREC_4 = 2'd1,
        PREC_2 = 2'd2
    } t_prec;

    // One queued job: all results caused by one input word
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  plane;
        logic [15:0] addr;
        logic [23:0] data;
        t_prec       prec;
        logic [3:0]  last_idx;
        t_status     status;
        logic [15:0] cnt_total;
        logic [15:0] cnt_temp;
        logic [15:0] cnt_spat;
    } t_job;

    function automatic logic [1:0] plane_of(input logic [6:0] kind);
        logic [1:0] p;
        case (kind)
            ROWK_TEMPORAL: p = PLANE_TEMPORAL;
            ROWK_SPAT_L:   p = PLANE_SPAT_L;
            ROWK_SPAT_R:   p = PLANE_SPAT_R;
            default:       p = PLANE_NONE;
        endcase
        return p;
    endfunction

endpackage

>>> hw/rtl/dspd_queue.sv
module dspd_queue import dspd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_job                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/dspd_front.sv
module dspd_front import dspd_pkg::*; #(
    parameter int HEADER_WORDS = HDR_WORDS_DEF,
    parameter int COUNT_BITS   = CNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [31:0] i_word,
    input  logic [7:0]  i_row_width,
    output logic        o_push,
    output t_job        o_job
);

    localparam int HL_BITS = $clog2(HEADER_WORDS + 1);
    localparam logic [HL_BITS-1:0]    HL_FULL = HL_BITS'(HEADER_WORDS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [HL_BITS-1:0]    r_header_left, n_header_left;
    t_prec                 r_prec, n_prec;
    logic [6:0]            r_row_kind, n_row_kind;
    logic [7:0]            r_row_index, n_row_index;
    logic [6:0]            r_groups_left, n_groups_left;
    logic                  r_discarding, n_discarding;
    logic [COUNT_BITS-1:0] r_cnt_total, n_cnt_total;
    logic [COUNT_BITS-1:0] r_cnt_temp, n_cnt_temp;
    logic [COUNT_BITS-1:0] r_cnt_spat, n_cnt_spat;

    logic                  is_term;
    logic [COUNT_BITS-1:0] total_inc, temp_inc, spat_inc;
    logic [1:0]            grp_plane, row_plane;
    logic [15:0]           base;
    logic [4:0]            g5;
    logic [6:0]            g7;
    t_job                  job;

    assign is_term   = (i_word == '0) || (&i_word);
    assign total_inc = (r_cnt_total == CNT_MAX) ? r_cnt_total : r_cnt_total + 1'b1;
    assign temp_inc  = (r_cnt_temp == CNT_MAX) ? r_cnt_temp : r_cnt_temp + 1'b1;
    assign spat_inc  = (r_cnt_spat == CNT_MAX) ? r_cnt_spat : r_cnt_spat + 1'b1;
    assign grp_plane = plane_of(r_row_kind);
    assign row_plane = plane_of(i_word[30:24]);
    assign base      = 16'(i_row_width) * 16'(r_row_index);
    assign g5        = i_word[30:26];
    assign g7        = i_word[30:24];

    // classify the word, advance frame state and build its job
    always_comb begin
        n_header_left = r_header_left;
        n_prec        = r_prec;
        n_row_kind    = r_row_kind;
        n_row_index   = r_row_index;
        n_groups_left = r_groups_left;
        n_discarding  = r_discarding;
        n_cnt_total   = r_cnt_total;
        n_cnt_temp    = r_cnt_temp;
        n_cnt_spat    = r_cnt_spat;
        o_push        = 1'b0;
        job           = '0;
        job.kind      = KIND_PIXEL;
        job.prec      = r_prec;
        job.status    = ST_OK;

        if (i_accept) begin
            if (r_header_left != '0) begin
                // header: only the first word carries the precision nibble
                if (r_header_left == HL_FULL) begin
                    case (i_word[3:0])
                        4'h0, 4'h8: n_prec = PREC_8;
                        4'h4:       n_prec = PREC_4;
                        4'h2:       n_prec = PREC_2;
                        default: begin
                            n_discarding = 1'b1;
                            o_push       = 1'b1;
                            job.kind     = KIND_ERROR;
                            job.status   = ST_BAD_PREC;
                        end
                    endcase
                end
                n_header_left = r_header_left - 1'b1;
            end else if (r_discarding) begin
                // skip to the next terminator
                if (is_term) begin
                    n_header_left = HL_FULL;
                    n_row_kind    = '0;
                    n_row_index   = '0;
                    n_groups_left = '0;
                    n_discarding  = 1'b0;
                    n_cnt_total   = '0;
                    n_cnt_temp    = '0;
                    n_cnt_spat    = '0;
                end
            end else if (r_groups_left != '0) begin
                // group word
                n_cnt_total   = total_inc;
                n_groups_left = r_groups_left - 1'b1;
                if (grp_plane == PLANE_TEMPORAL) begin
                    n_cnt_temp = temp_inc;
                end else if (grp_plane != PLANE_NONE) begin
                    n_cnt_spat = spat_inc;
                end
                if (i_word[31] && grp_plane != PLANE_NONE) begin
                    o_push    = 1'b1;
                    job.plane = grp_plane;
                    case (r_prec)
                        PREC_2: begin
                            job.addr     = base + {8'b0, g5, 3'b0} + {9'b0, g5, 2'b0};
                            job.data     = i_word[25:2];
                            job.last_idx = (g5 == GROUP_SHORT) ? 4'd3 : 4'd11;
                        end
                        PREC_4: begin
                            job.addr     = base + {7'b0, g7, 2'b0};
                            job.data     = {i_word[23:8], 8'b0};
                            job.last_idx = 4'd3;
                        end
                        default: begin
                            job.addr     = base + {8'b0, g7, 1'b0};
                            job.data     = {i_word[23:8], 8'b0};
                            job.last_idx = 4'd1;
                        end
                    endcase
                end
            end else if (is_term) begin
                // frame end: summary, then a fresh frame keeping precision
                o_push        = 1'b1;
                job.kind      = KIND_SUMMARY;
                n_header_left = HL_FULL;
                n_row_kind    = '0;
                n_row_index   = '0;
                n_groups_left = '0;
                n_discarding  = 1'b0;
                n_cnt_total   = '0;
                n_cnt_temp    = '0;
                n_cnt_spat    = '0;
            end else begin
                // row word
                n_cnt_total = total_inc;
                if (i_word[31:27] == 5'd1) begin
                    // frame-count word, counted only
                end else if (i_word[31]) begin
                    n_discarding = 1'b1;
                    o_push       = 1'b1;
                    job.kind     = KIND_ERROR;
                    job.status   = ST_ROW_LOST;
                end else begin
                    n_row_kind    = i_word[30:24];
                    n_groups_left = i_word[23:17];
                    n_row_index   = i_word[15:8];
                    if (row_plane == PLANE_TEMPORAL) begin
                        n_cnt_temp = temp_inc;
                    end else if (row_plane != PLANE_NONE) begin
                        n_cnt_spat = spat_inc;
                    end
                end
            end
        end

        // results carry counters including this word; a summary the frame's own
        if (job.kind == KIND_SUMMARY) begin
            job.cnt_total = 16'(r_cnt_total);
            job.cnt_temp  = 16'(r_cnt_temp);
            job.cnt_spat  = 16'(r_cnt_spat);
        end else begin
            job.cnt_total = 16'(n_cnt_total);
            job.cnt_temp  = 16'(n_cnt_temp);
            job.cnt_spat  = 16'(n_cnt_spat);
        end
        o_job = job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_left <= HL_FULL;
            r_prec        <= PREC_8;
            r_row_kind    <= '0;
            r_row_index   <= '0;
            r_groups_left <= '0;
            r_discarding  <= 1'b0;
            r_cnt_total   <= '0;
            r_cnt_temp    <= '0;
            r_cnt_spat    <= '0;
        end else begin
            r_header_left <= n_header_left;
            r_prec        <= n_prec;
            r_row_kind    <= n_row_kind;
            r_row_index   <= n_row_index;
            r_groups_left <= n_groups_left;
            r_discarding  <= n_discarding;
            r_cnt_total   <= n_cnt_total;
            r_cnt_temp    <= n_cnt_temp;
            r_cnt_spat    <= n_cnt_spat;
        end
    end

endmodule

>>> hw/rtl/dspd_back.sv
module dspd_back import dspd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_job              i_head,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [1:0]        o_result_kind,
    output logic [1:0]        o_plane_select,
    output logic [15:0]       o_pixel_address,
    output logic signed [7:0] o_pixel_value,
    output logic [1:0]        o_status_code,
    output logic [15:0]       o_total_words,
    output logic [15:0]       o_temporal_words,
    output logic [15:0]       o_spatial_words,
    output logic              o_last_of_run
);

    logic        r_valid, n_valid;
    logic [3:0]  r_idx, n_idx;
    logic [1:0]  r_kind, r_plane, r_status;
    logic [15:0] r_addr, r_total, r_temp, r_spat;
    logic [7:0]  r_value;
    logic        r_last;

    logic        advance;
    logic        is_last;
    logic [4:0]  amt;
    logic [23:0] shifted;
    logic [7:0]  value;

    assign advance = !i_empty && (!r_valid || !i_stall);
    assign is_last = (r_idx == i_head.last_idx);
    assign o_pop   = advance && is_last;

    // pick pixel r_idx out of the group data, most significant first
    always_comb begin
        case (i_head.prec)
            PREC_4:  amt = 5'd20 - 5'({r_idx, 2'b0});
            PREC_2:  amt = 5'd22 - 5'({r_idx, 1'b0});
            default: amt = 5'd16 - 5'({r_idx, 3'b0});
        endcase
        shifted = i_head.data >> amt;
        case (i_head.prec)
            PREC_4: value = {shifted[3:0], 4'b0};
            PREC_2: begin
                case (shifted[1:0])
                    2'd1:    value = 8'h7f;
                    2'd3:    value = 8'h81;
                    default: value = {6'b0, shifted[1:0]};
                endcase
            end
            default: value = shifted[7:0];
        endcase
    end

    // beat counter within the current job and output valid
    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (advance) begin
            n_valid = 1'b1;
            n_idx   = is_last ? 4'd0 : r_idx + 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind   <= i_head.kind;
            r_plane  <= i_head.plane;
            r_addr   <= i_head.addr + 16'(r_idx);
            r_value  <= value;
            r_status <= i_head.status;
            r_total  <= i_head.cnt_total;
            r_temp   <= i_head.cnt_temp;
            r_spat   <= i_head.cnt_spat;
            r_last   <= is_last;
        end
    end

    assign o_valid          = r_valid;
    assign o_result_kind    = r_kind;
    assign o_plane_select   = r_plane;
    assign o_pixel_address  = r_addr;
    assign o_pixel_value    = r_value;
    assign o_status_code    = r_status;
    assign o_total_words    = r_total;
    assign o_temporal_words = r_temp;
    assign o_spatial_words  = r_spat;
    assign o_last_of_run    = r_last;

endmodule

>>> hw/rtl/diff_sensor_packet_decoder.sv
// A four-job queue lets input run ahead; a word's first result passes the queue
// and then the output register. One word in per cycle unless the queue is full;
// one result beat out per cycle unless stalled; a group word gives 2, 4 or 12 beats.
// Synchronous active-low reset: queue and output empty, new frame expecting header,
// 8-bit precision, row width 160.
module diff_sensor_packet_decoder import dspd_pkg::*; #(
    parameter int HEADER_WORDS = HDR_WORDS_DEF,
    parameter int COUNT_BITS   = CNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // word input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_stream_word,
    // result output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_result_kind,
    output logic [1:0]           o_plane_select,
    output logic [15:0]          o_pixel_address,
    output logic signed [7:0]    o_pixel_value,
    output logic [1:0]           o_status_code,
    output logic [15:0]          o_total_words,
    output logic [15:0]          o_temporal_words,
    output logic [15:0]          o_spatial_words,
    output logic                 o_last_of_run,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [7:0] r_row_width;
    logic       accept;
    logic       push, pop, full, empty;
    t_job       push_job, head_job;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_BITS-1] == REG_ROW_WIDTH) ? {24'b0, r_row_width} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
        end else if (psel && penable && pwrite && paddr[ADDR_BITS-1] == REG_ROW_WIDTH) begin
            r_row_width <= pwdata[7:0];
        end
    end

    assign o_stall = full;
    assign accept  = i_valid && !full;

    dspd_front #(
        .HEADER_WORDS (HEADER_WORDS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_word      (i_stream_word),
        .i_row_width (r_row_width),
        .o_push      (push),
        .o_job       (push_job)
    );

    dspd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    dspd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_head           (head_job),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_result_kind    (o_result_kind),
        .o_plane_select   (o_plane_select),
        .o_pixel_address  (o_pixel_address),
        .o_pixel_value    (o_pixel_value),
        .o_status_code    (o_status_code),
        .o_total_words    (o_total_words),
        .o_temporal_words (o_temporal_words),
        .o_spatial_words  (o_spatial_words),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
